// ===== hw/rtl/chm_pkg.sv =====
// shared constants for the chained hash map
package chm_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   // request kind carried in req_tuser
   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   // response status
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== hw/rtl/chm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/chained_hash_map.sv =====
// chained hash map: bucket head ram plus a node pool ram walked one node per cycle
// a request is accepted in idle, reads its bucket head and walks its chain, then
// waits in a finish state until the output register is free; the next request is
// taken only once that response is registered
// reset (synchronous) starts a clearing pass over all the bucket heads,
// during which req_tready stays low; the node pool is never cleared
module chained_hash_map
   import chm_pkg::*;
#(
   parameter int BUCKETS      = 256,
   parameter int POOL_ENTRIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // key [31:0], value_ref [63:32], value_off [95:64]
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // result_ref [31:0], result_off [63:32]
   output logic [1:0]   rsp_tuser    // status [0], found [1]
);

   localparam int BW = $clog2(BUCKETS);
   localparam int PW = $clog2(POOL_ENTRIES);
   localparam int HW = $clog2(POOL_ENTRIES + 1);
   localparam int NW = KEY_W + 2 * VAL_W + HW;

   localparam logic [BW-1:0] BMASK    = BW'(BUCKETS - 1);
   localparam logic [HW-1:0] POOL_LIM = HW'(POOL_ENTRIES);
   localparam logic [HW-1:0] ONE      = HW'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_NODE,
      ST_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic               op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   vref_ff, vref_in;
   logic [VAL_W-1:0]   voff_ff, voff_in;
   logic [BW-1:0]      bkt_ff, bkt_in;
   logic [HW-1:0]      head_ff, head_in;
   logic [HW-1:0]      cur_ff, cur_in;
   logic [HW-1:0]      used_ff, used_in;
   logic [BW-1:0]      clr_ff, clr_in;
   logic               res_status_ff, res_status_in;
   logic               res_found_ff, res_found_in;
   logic [VAL_W-1:0]   res_ref_ff, res_ref_in;
   logic [VAL_W-1:0]   res_off_ff, res_off_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]         rsp_tuser_ff, rsp_tuser_in;

   // bucket head ram ports
   logic               hd_wr_en, hd_rd_en;
   logic [BW-1:0]      hd_wr_addr, hd_rd_addr;
   logic [HW-1:0]      hd_wr_data, hd_rd_data;

   // node pool ram ports
   logic               nd_wr_en, nd_rd_en;
   logic [PW-1:0]      nd_wr_addr, nd_rd_addr;
   logic [NW-1:0]      nd_wr_data, nd_rd_data;

   logic [KEY_W-1:0]   nd_key;
   logic [HW-1:0]      nd_next;
   logic [VAL_W-1:0]   nd_ref, nd_off;
   logic [HW-1:0]      cur_idx, next_idx, used_inc;
   logic               req_fire;

   chm_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (hd_wr_en),
      .wr_addr (hd_wr_addr),
      .wr_data (hd_wr_data),
      .rd_en   (hd_rd_en),
      .rd_addr (hd_rd_addr),
      .rd_data (hd_rd_data)
   );

   chm_ram #(.WIDTH(NW), .DEPTH(POOL_ENTRIES)) u_node_ram (
      .clock   (clock),
      .wr_en   (nd_wr_en),
      .wr_addr (nd_wr_addr),
      .wr_data (nd_wr_data),
      .rd_en   (nd_rd_en),
      .rd_addr (nd_rd_addr),
      .rd_data (nd_rd_data)
   );

   assign nd_key  = nd_rd_data[KEY_W-1:0];
   assign nd_ref  = nd_rd_data[KEY_W +: VAL_W];
   assign nd_off  = nd_rd_data[KEY_W+VAL_W +: VAL_W];
   assign nd_next = nd_rd_data[KEY_W+2*VAL_W +: HW];

   assign cur_idx  = cur_ff - ONE;
   assign next_idx = nd_next - ONE;
   assign used_inc = used_ff + ONE;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      vref_in       = vref_ff;
      voff_in       = voff_ff;
      bkt_in        = bkt_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      used_in       = used_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_ref_in    = res_ref_ff;
      res_off_in    = res_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      hd_wr_en   = 1'b0;
      hd_wr_addr = bkt_ff;
      hd_wr_data = '0;
      hd_rd_en   = 1'b0;
      hd_rd_addr = req_tdata[BW-1:0] & BMASK;
      nd_wr_en   = 1'b0;
      nd_wr_addr = used_ff[PW-1:0];
      nd_wr_data = {head_ff, voff_ff, vref_ff, key_ff};
      nd_rd_en   = 1'b0;
      nd_rd_addr = cur_idx[PW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            hd_wr_en   = 1'b1;
            hd_wr_addr = clr_ff;
            clr_in     = clr_ff + BW'(1);
            if (clr_ff == BMASK) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_tuser;
               key_in   = req_tdata[KEY_W-1:0];
               vref_in  = req_tdata[KEY_W +: VAL_W];
               voff_in  = req_tdata[KEY_W+VAL_W +: VAL_W];
               bkt_in   = req_tdata[BW-1:0] & BMASK;
               hd_rd_en = 1'b1;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            head_in = hd_rd_data;
            if (hd_rd_data == '0 || hd_rd_data > POOL_LIM) begin
               // empty bucket: miss without walking
               res_found_in = 1'b0;
               res_ref_in   = '0;
               res_off_in   = '0;
               res_status_in = STATUS_DONE;
               if (op_ff == OP_PUT) begin
                  if (used_ff >= POOL_LIM) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     nd_wr_en   = 1'b1;
                     nd_wr_data = {hd_rd_data, voff_ff, vref_ff, key_ff};
                     hd_wr_en   = 1'b1;
                     hd_wr_data = used_inc;
                     used_in    = used_inc;
                  end
               end
               state_in = ST_FIN;
            end else begin
               cur_in     = hd_rd_data;
               nd_rd_en   = 1'b1;
               nd_rd_addr = PW'(hd_rd_data - ONE);
               state_in   = ST_NODE;
            end
         end
         ST_NODE: begin
            res_status_in = STATUS_DONE;
            res_ref_in    = '0;
            res_off_in    = '0;
            if (nd_key == key_ff) begin
               res_found_in = 1'b1;
               if (op_ff == OP_PUT) begin
                  // update in place, key and link kept
                  nd_wr_en   = 1'b1;
                  nd_wr_addr = cur_idx[PW-1:0];
                  nd_wr_data = {nd_next, voff_ff, vref_ff, nd_key};
               end else begin
                  res_ref_in = nd_ref;
                  res_off_in = nd_off;
               end
               state_in = ST_FIN;
            end else if (nd_next == '0 || nd_next > POOL_LIM) begin
               res_found_in = 1'b0;
               if (op_ff == OP_PUT) begin
                  if (used_ff >= POOL_LIM) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     nd_wr_en   = 1'b1;
                     nd_wr_data = {head_ff, voff_ff, vref_ff, key_ff};
                     hd_wr_en   = 1'b1;
                     hd_wr_data = used_inc;
                     used_in    = used_inc;
                  end
               end
               state_in = ST_FIN;
            end else begin
               cur_in     = nd_next;
               nd_rd_en   = 1'b1;
               nd_rd_addr = next_idx[PW-1:0];
            end
         end
         ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = {res_off_ff, res_ref_ff};
               rsp_tuser_in = {res_found_ff, res_status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      vref_ff       <= vref_in;
      voff_ff       <= voff_in;
      bkt_ff        <= bkt_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_ref_ff    <= res_ref_in;
      res_off_ff    <= res_off_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
